// File: rtl/core/art_pkg.sv
// ----------------------------------------------------------------------------
// Aging route table package
// Shared sizes, operation and status codes, and the structs that travel
// along the cell chain and from the controller to the cells.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned HW_W    = 48;

  localparam logic [1:0] KIND_QUERY  = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_RELAY  = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_PLACEHOLDER = 3'd1;
  localparam logic [2:0] ST_STALE       = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd4;

  localparam logic [31:0] EXPIRY_RESET = 32'd5000;

  // Search record that moves one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] found_idx;
    logic             has_free;
    logic [IDX_W-1:0] free_idx;
    logic             has_route;
    logic [HW_W-1:0]  gw_addr;
    logic [3:0]       port;
    logic [7:0]       hops;
    logic [31:0]      stamp;
    logic [31:0]      last_bcast;
  } art_scan_t;

  // Write-back command broadcast to all cells.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             take;
    logic             route;
    logic             free;
    logic             bcast;
  } art_wr_t;

endpackage

// File: rtl/core/art_cell.sv
// ----------------------------------------------------------------------------
// Aging route table cell
// Holds one table slot, adds itself to the passing search record and
// applies write-back commands addressed to its index.
// ----------------------------------------------------------------------------
module art_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [art_pkg::IDX_W-1:0]  idx_i,
  input  logic [31:0]                key_i,
  input  logic [31:0]                now_i,
  input  logic [art_pkg::HW_W-1:0]   next_hop_i,
  input  logic [3:0]                 port_i,
  input  logic [7:0]                 hops_i,
  input  logic [31:0]                bcast_i,
  input  art_pkg::art_wr_t           wr_i,
  input  art_pkg::art_scan_t         scan_i,
  output art_pkg::art_scan_t         scan_o
);
  import art_pkg::*;

  logic            used_q, has_route_q;
  logic [31:0]     key_q, stamp_q, last_bcast_q;
  logic [HW_W-1:0] next_hop_q;
  logic [3:0]      port_q;
  logic [7:0]      hops_q;
  art_scan_t       scan_d, scan_q;
  logic            valid_q;
  logic            sel;

  assign sel = wr_i.en && (wr_i.idx == idx_i);

  always_comb begin
    scan_d = scan_i;
    if (!scan_i.found && used_q && (key_q == key_i)) begin
      scan_d.found      = 1'b1;
      scan_d.found_idx  = idx_i;
      scan_d.has_route  = has_route_q;
      scan_d.gw_addr    = next_hop_q;
      scan_d.port       = port_q;
      scan_d.hops       = hops_q;
      scan_d.stamp      = stamp_q;
      scan_d.last_bcast = last_bcast_q;
    end
    if (!scan_i.has_free && !used_q) begin
      scan_d.has_free = 1'b1;
      scan_d.free_idx = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= 1'b0;
      has_route_q <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      valid_q <= scan_i.valid;
      if (sel && wr_i.free) begin
        used_q      <= 1'b0;
        has_route_q <= 1'b0;
      end
      if (sel && wr_i.take) begin
        used_q      <= 1'b1;
        has_route_q <= 1'b0;
      end
      if (sel && wr_i.route) begin
        has_route_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    if (sel && wr_i.take) begin
      key_q        <= key_i;
      stamp_q      <= now_i;
      last_bcast_q <= 32'd0;
      next_hop_q   <= '0;
      port_q       <= 4'd0;
      hops_q       <= 8'd0;
    end
    if (sel && wr_i.route) begin
      next_hop_q <= next_hop_i;
      port_q     <= port_i;
      hops_q     <= hops_i;
      stamp_q    <= now_i;
    end
    if (sel && wr_i.bcast) begin
      last_bcast_q <= bcast_i;
    end
  end

  // The valid bit comes from the reset flop; the payload needs no reset.
  always_comb begin
    scan_o       = scan_q;
    scan_o.valid = valid_q;
  end

endmodule

// File: rtl/core/aging_route_table_core.sv
// ----------------------------------------------------------------------------
// Aging route table core
// Route table keyed by destination address with expiry, built as a chain
// of slot cells searched by a record that moves one cell per cycle.
// ----------------------------------------------------------------------------
// The search record walks one cell per cycle down the chain to the done
// strobe. A new item is taken only while busy is low, and it may start in
// the cycle that shows the previous result. The receiver cannot stall.
// Reset empties every slot and sets the expiry to 5000 ms.
module aging_route_table_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                kind_i,
  input  logic [31:0]               now_ms_i,
  input  logic [31:0]               dest_addr_i,
  input  logic [art_pkg::HW_W-1:0]  offered_next_hop_i,
  input  logic [3:0]                offered_port_i,
  input  logic [7:0]                offered_hops_i,
  input  logic [31:0]               bcast_id_i,
  output logic                      done_o,
  output logic [2:0]                status_o,
  output logic                      decision_o,
  output logic [art_pkg::HW_W-1:0]  route_next_hop_o,
  output logic [3:0]                route_port_o,
  output logic [7:0]                route_hops_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import art_pkg::*;

  // Configuration: only the expiry register exists, at byte address 0.
  logic [31:0] expiry_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? expiry_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= EXPIRY_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      expiry_q <= pwdata;
    end
  end

  // The item is held for the whole walk down the chain.
  logic [1:0]      kind_q;
  logic [31:0]     now_q, key_q, bcast_q;
  logic [HW_W-1:0] nh_q;
  logic [3:0]      port_q;
  logic [7:0]      hops_q;
  logic            busy_q;
  logic            accept;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      now_q   <= now_ms_i;
      key_q   <= dest_addr_i;
      bcast_q <= bcast_id_i;
      nh_q    <= offered_next_hop_i;
      port_q  <= offered_port_i;
      hops_q  <= offered_hops_i;
    end
  end

  // The chain: cell 0 receives a fresh record in the cycle after the start.
  art_scan_t chain [ENTRIES+1];
  art_wr_t   wr;
  logic      inject_q;

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = inject_q;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    art_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (IDX_W'(i)),
      .key_i      (key_q),
      .now_i      (now_q),
      .next_hop_i (nh_q),
      .port_i     (port_q),
      .hops_i     (hops_q),
      .bcast_i    (bcast_q),
      .wr_i       (wr),
      .scan_i     (chain[i]),
      .scan_o     (chain[i+1])
    );
  end

  // When the record leaves the last cell, the outcome is decided and the
  // write-back goes to the chosen slot in the same cycle.
  art_scan_t   res;
  logic [31:0] age;
  logic        stale, upd_ok;
  logic [2:0]  status_d;
  logic        decision_d, show_route;

  assign res   = chain[ENTRIES];
  assign age   = now_q - res.stamp;
  assign stale = !res.has_route || (age >= expiry_q);

  always_comb begin
    wr         = '0;
    status_d   = ST_OK;
    decision_d = 1'b0;
    show_route = 1'b0;
    upd_ok     = !res.found || stale || (hops_q < res.hops) ||
                 ((hops_q == res.hops) && (nh_q != res.gw_addr));
    case (kind_q)
      KIND_QUERY: begin
        if (!res.found) begin
          if (res.has_free) begin
            wr.take  = 1'b1;
            wr.idx   = res.free_idx;
            status_d = ST_PLACEHOLDER;
          end else begin
            status_d = ST_FULL;
          end
        end else if (stale) begin
          wr.free  = 1'b1;
          wr.idx   = res.found_idx;
          status_d = ST_STALE;
        end else begin
          show_route = 1'b1;
        end
      end
      KIND_UPDATE: begin
        if (upd_ok) begin
          if (res.found) begin
            wr.route   = 1'b1;
            wr.idx     = res.found_idx;
            decision_d = 1'b1;
          end else if (res.has_free) begin
            wr.take    = 1'b1;
            wr.route   = 1'b1;
            wr.idx     = res.free_idx;
            decision_d = 1'b1;
          end else begin
            status_d = ST_FULL;
          end
        end
      end
      KIND_RELAY: begin
        if (!res.found) begin
          status_d = ST_NOT_FOUND;
        end else if (res.last_bcast < bcast_q) begin
          wr.bcast   = 1'b1;
          wr.idx     = res.found_idx;
          decision_d = 1'b1;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
    wr.en = res.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      inject_q <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      inject_q <= accept;
      done_o   <= res.valid;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (res.valid) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_o         <= status_d;
      decision_o       <= decision_d;
      route_next_hop_o <= show_route ? res.gw_addr : '0;
      route_port_o     <= show_route ? res.port : 4'd0;
      route_hops_o     <= show_route ? res.hops : 8'd0;
    end
  end

endmodule
